FILE: hw/rtl/hrlp_pkg.sv
// Types and constants for the HTTP request line parser.
`timescale 1ns / 1ps

package hrlp_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
	} hrlp_byte_t;

	typedef struct packed {
		logic [3:0]  method_code;
		logic [1:0]  version_code;
		logic        resource_found;
		logic [11:0] resource_start;
		logic [11:0] resource_length;
		logic        query_found;
		logic [11:0] query_start;
		logic [11:0] query_length;
		logic        parent_ref;
		logic [1:0]  verdict;
		logic [12:0] line_length;
		logic        line_overflow;
	} hrlp_line_t;

	localparam int OUT_DEPTH    = 4;
	localparam int METHOD_COUNT = 10;
	localparam int VER_LEAD_LEN = 5;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_QM    = 8'h3F;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;

	localparam logic [3:0] METHOD_NONE = 4'd0;

	localparam logic [1:0] VER_UNKNOWN = 2'd0;
	localparam logic [1:0] VER_1_0     = 2'd1;
	localparam logic [1:0] VER_1_1     = 2'd2;

	localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
	localparam logic [1:0] VERDICT_BAD    = 2'd1;
	localparam logic [1:0] VERDICT_FORBID = 2'd2;

	// version matcher: 0..4 = chars of "HTTP/" matched, then major, dot, minor, done
	localparam logic [3:0] VS_SEARCH = 4'd0;
	localparam logic [3:0] VS_MAJOR  = 4'd5;
	localparam logic [3:0] VS_DOT    = 4'd6;
	localparam logic [3:0] VS_MINOR  = 4'd7;
	localparam logic [3:0] VS_DONE   = 4'd8;

	localparam logic [7:0] VER_LEAD [VER_LEAD_LEN] = '{"H", "T", "T", "P", "/"};

	localparam logic [3:0] METHOD_LENS [METHOD_COUNT] = '{
		4'd7, 4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd7, 4'd7, 4'd5
	};

	localparam logic [7:0] METHOD_NAMES [METHOD_COUNT][8] = '{
		'{"U", "N", "K", "N", "O", "W", "N", 8'h00},
		'{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
		'{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00},
		'{"O", "P", "T", "I", "O", "N", "S", 8'h00},
		'{"C", "O", "N", "N", "E", "C", "T", 8'h00},
		'{"P", "A", "T", "C", "H", 8'h00, 8'h00, 8'h00}
	};

endpackage

FILE: hw/rtl/http_request_line_parser_core.sv
// Top level of the HTTP request line parser: byte scanner, report stage, result queue.
`timescale 1ns / 1ps

// Request bytes enter on the byte channel (byte_valid, byte_stall, byte_data);
// one parsed request line leaves on the line channel (line_valid, line_stall,
// line_data) for every line that ends, either at CR LF or at a byte that has
// stream_end set. Bytes that do not end a line produce no transaction.
// Throughput: one byte per cycle while byte_stall is low. Every byte goes through
// the scanner logic, which updates the per-line position latches and matchers.
// A byte that ends a line passes through the input register, the scanner
// register and a result queue entry before it shows up as a line transaction
// on line_valid.
// Results wait in a four-entry queue. byte_stall is registered and rises once
// the queue plus the transactions still in the pipe could fill it, so a
// stalled line channel holds back the byte channel and no result is ever lost.
// Reset (arst_n low) empties the pipe and the queue and starts a fresh line.
// LINE_MAX_BYTES sets the line length limit and the width of the position
// latches; bytes beyond it only set the overflow flag.

module http_request_line_parser_core #(
	parameter int LINE_MAX_BYTES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  hrlp_pkg::hrlp_byte_t byte_data,
	output logic                 line_valid,
	input  logic                 line_stall,
	output hrlp_pkg::hrlp_line_t line_data
);

	localparam int PW = $clog2(LINE_MAX_BYTES + 1);
	localparam int CW = $clog2(hrlp_pkg::OUT_DEPTH + 1);
	localparam int AW = $clog2(hrlp_pkg::OUT_DEPTH);

	typedef struct packed {
		logic [PW-1:0] pos;
		logic [hrlp_pkg::METHOD_COUNT-1:0] cand;
		logic          sp_v;
		logic [PW-1:0] sp;
		logic          rq_v;
		logic [PW-1:0] rq;
		logic          rs_v;
		logic [PW-1:0] rsp;
		logic          fq_v;
		logic [PW-1:0] fq;
		logic          qs_v;
		logic [PW-1:0] qsp;
		logic          dd_v;
		logic [PW-1:0] dd;
		logic [3:0]    vstate;
		logic [1:0]    vres;
		logic [7:0]    prev;
		logic          cr_pend;
		logic          slash;
		logic          ovf;
	} line_st_t;

	function automatic line_st_t clear_st();
		line_st_t r;
		r = '0;
		r.cand = '1;
		r.vstate = hrlp_pkg::VS_SEARCH;
		r.vres = hrlp_pkg::VER_UNKNOWN;
		return r;
	endfunction

	function automatic line_st_t feed(line_st_t s, logic [7:0] b);
		line_st_t r;
		logic [PW:0] p_ext;
		logic [PW:0] sp_ext;
		r = s;
		p_ext = {1'b0, s.pos};
		sp_ext = {1'b0, s.sp};
		if (s.pos >= PW'(LINE_MAX_BYTES)) begin
			r.ovf = 1'b1;
		end else begin
			for (int i = 0; i < hrlp_pkg::METHOD_COUNT; i++) begin
				if ((s.pos < PW'(hrlp_pkg::METHOD_LENS[i])) &&
				    (hrlp_pkg::METHOD_NAMES[i][s.pos[2:0]] != b)) begin
					r.cand[i] = 1'b0;
				end
			end
			if (b == hrlp_pkg::CH_SP) begin
				if (!s.sp_v) begin
					r.sp_v = 1'b1;
					r.sp = s.pos;
				end else if (!s.rs_v) begin
					r.rs_v = 1'b1;
					r.rsp = s.pos;
				end
				if (s.fq_v && !s.qs_v) begin
					r.qs_v = 1'b1;
					r.qsp = s.pos;
				end
			end else if (b == hrlp_pkg::CH_QM) begin
				if (!s.fq_v) begin
					r.fq_v = 1'b1;
					r.fq = s.pos;
				end
				if (s.sp_v && !s.rq_v) begin
					r.rq_v = 1'b1;
					r.rq = s.pos;
				end
			end
			if (s.sp_v) begin
				if (b == hrlp_pkg::CH_SLASH && p_ext == sp_ext + 1'b1) begin
					r.slash = 1'b1;
				end
				if (b == hrlp_pkg::CH_DOT && s.prev == hrlp_pkg::CH_DOT &&
				    p_ext >= sp_ext + 2'd2 && !s.dd_v) begin
					r.dd_v = 1'b1;
					r.dd = s.pos - 1'b1;
				end
			end
			if (s.vstate < hrlp_pkg::VS_MAJOR) begin
				if (b == hrlp_pkg::VER_LEAD[s.vstate[2:0]]) begin
					r.vstate = s.vstate + 1'b1;
				end else if (b == hrlp_pkg::CH_H) begin
					r.vstate = 4'd1;
				end else begin
					r.vstate = hrlp_pkg::VS_SEARCH;
				end
			end else begin
				case (s.vstate)
					hrlp_pkg::VS_MAJOR: begin
						r.vstate = (b == hrlp_pkg::CH_ONE) ? hrlp_pkg::VS_DOT
						                                   : hrlp_pkg::VS_DONE;
					end
					hrlp_pkg::VS_DOT: begin
						r.vstate = (b == hrlp_pkg::CH_DOT) ? hrlp_pkg::VS_MINOR
						                                   : hrlp_pkg::VS_DONE;
					end
					hrlp_pkg::VS_MINOR: begin
						if (b == hrlp_pkg::CH_ZERO) begin
							r.vres = hrlp_pkg::VER_1_0;
						end else if (b == hrlp_pkg::CH_ONE) begin
							r.vres = hrlp_pkg::VER_1_1;
						end
						r.vstate = hrlp_pkg::VS_DONE;
					end
					default: begin
						r.vstate = s.vstate;
					end
				endcase
			end
			r.prev = b;
			r.pos = s.pos + 1'b1;
		end
		return r;
	endfunction

	function automatic hrlp_pkg::hrlp_line_t report(line_st_t s);
		hrlp_pkg::hrlp_line_t o;
		logic [3:0]  meth;
		logic        end_v;
		logic [PW:0] endp;
		logic [PW:0] rs;
		logic [PW:0] rl;
		logic [PW:0] qs;
		logic        rfound;
		logic        parent;
		logic        qfound;
		o = '0;
		meth = hrlp_pkg::METHOD_NONE;
		for (int i = hrlp_pkg::METHOD_COUNT - 1; i >= 0; i--) begin
			if (s.cand[i] && s.pos >= PW'(hrlp_pkg::METHOD_LENS[i])) begin
				meth = 4'(i);
			end
		end
		end_v = s.rq_v | s.rs_v;
		endp = s.rq_v ? {1'b0, s.rq} : {1'b0, s.rsp};
		rs = '0;
		rl = '0;
		rfound = 1'b0;
		parent = 1'b0;
		if (s.sp_v && end_v) begin
			rfound = 1'b1;
			rs = {1'b0, s.sp} + 1'b1;
			rl = endp - ({1'b0, s.sp} + 1'b1);
			parent = s.dd_v && ({1'b0, s.dd} + 1'b1 < endp);
			if (rl != '0 && s.slash) begin
				rs = rs + 1'b1;
				rl = rl - 1'b1;
			end
		end
		qfound = s.fq_v && s.qs_v;
		qs = '0;
		if (qfound) begin
			qs = {1'b0, s.fq} + 1'b1;
			o.query_length = 12'({1'b0, s.qsp} - qs);
		end
		o.method_code = meth;
		o.version_code = s.vres;
		o.resource_found = rfound;
		o.resource_start = 12'(rs);
		o.resource_length = 12'(rl);
		o.query_found = qfound;
		o.query_start = 12'(qs);
		o.parent_ref = parent;
		if (s.ovf || meth == hrlp_pkg::METHOD_NONE || !rfound ||
		    s.vres == hrlp_pkg::VER_UNKNOWN) begin
			o.verdict = hrlp_pkg::VERDICT_BAD;
		end else if (parent) begin
			o.verdict = hrlp_pkg::VERDICT_FORBID;
		end else begin
			o.verdict = hrlp_pkg::VERDICT_ACCEPT;
		end
		o.line_length = 13'(s.pos);
		o.line_overflow = s.ovf;
		return o;
	endfunction

	logic                 accept;
	logic                 v_s1;
	hrlp_pkg::hrlp_byte_t item_s1;
	line_st_t             st_q;
	line_st_t             st_d;
	line_st_t             snap_c;
	logic                 rep_c;
	logic                 rep_s2;
	line_st_t             snap_s2;
	hrlp_pkg::hrlp_line_t wr_line;
	hrlp_pkg::hrlp_line_t fifo_q [hrlp_pkg::OUT_DEPTH];
	logic [AW-1:0]        wr_ptr_q;
	logic [AW-1:0]        rd_ptr_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        cnt_d;
	logic                 pop;
	logic [CW:0]          credit_sum;
	logic                 stall_q;

	assign accept = byte_valid && !stall_q;
	assign byte_stall = stall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= byte_data;
		end
	end

	always_comb begin
		line_st_t s0;
		s0 = st_q;
		st_d = st_q;
		snap_c = st_q;
		rep_c = 1'b0;
		if (v_s1) begin
			if (s0.cr_pend) begin
				s0.cr_pend = 1'b0;
				if (item_s1.data_byte == hrlp_pkg::CH_LF) begin
					rep_c = 1'b1;
				end else begin
					s0 = feed(s0, hrlp_pkg::CH_CR);
				end
			end
			if (rep_c) begin
				snap_c = s0;
				st_d = clear_st();
			end else if (item_s1.stream_end) begin
				rep_c = 1'b1;
				snap_c = feed(s0, item_s1.data_byte);
				st_d = clear_st();
			end else if (item_s1.data_byte == hrlp_pkg::CH_CR) begin
				st_d = s0;
				st_d.cr_pend = 1'b1;
			end else begin
				st_d = feed(s0, item_s1.data_byte);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= clear_st();
			rep_s2 <= 1'b0;
		end else begin
			st_q <= st_d;
			rep_s2 <= rep_c;
		end
	end

	always_ff @(posedge clk) begin
		if (rep_c) begin
			snap_s2 <= snap_c;
		end
	end

	assign wr_line = report(snap_s2);

	always_ff @(posedge clk) begin
		if (rep_s2) begin
			fifo_q[wr_ptr_q] <= wr_line;
		end
	end

	assign line_valid = cnt_q != '0;
	assign line_data = fifo_q[rd_ptr_q];
	assign pop = line_valid && !line_stall;

	always_comb begin
		cnt_d = cnt_q;
		if (rep_s2 && !pop) begin
			cnt_d = cnt_q + 1'b1;
		end else if (!rep_s2 && pop) begin
			cnt_d = cnt_q - 1'b1;
		end
	end

	assign credit_sum = {1'b0, cnt_d} + (CW + 1)'(accept) + (CW + 1)'(v_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
			stall_q <= 1'b0;
		end else begin
			if (rep_s2) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_d;
			stall_q <= credit_sum >= (CW + 1)'(hrlp_pkg::OUT_DEPTH);
		end
	end

`ifndef SYNTH
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cnt_q} + (CW + 1)'(v_s1) + (CW + 1)'(rep_s2)) <=
		(CW + 1)'(hrlp_pkg::OUT_DEPTH))
		else $error("result queue could overrun");

	a_no_full_write: assert property (@(posedge clk) disable iff (!arst_n)
		(rep_s2 && cnt_q == CW'(hrlp_pkg::OUT_DEPTH)) |-> pop)
		else $error("write into full result queue");

	a_accept_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rep_s2 && wr_line.verdict == hrlp_pkg::VERDICT_ACCEPT) |->
		(wr_line.method_code != hrlp_pkg::METHOD_NONE &&
		 wr_line.version_code != hrlp_pkg::VER_UNKNOWN &&
		 wr_line.resource_found && !wr_line.line_overflow))
		else $error("accept verdict on a malformed line");

	a_line_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		rep_c |=> (st_q.pos == '0 && !st_q.sp_v && !st_q.cr_pend && !st_q.ovf))
		else $error("line state not cleared after report");
`endif

endmodule

FILE: tb/testbench.sv
// Testbench for the HTTP request line parser: directed and random request streams, self-checked.
`timescale 1ns / 1ps

module testbench;

	localparam int LINE_MAX      = 4096;
	localparam int NO_POS        = -1;
	localparam int METHOD_TOTAL  = 10;
	localparam int RANDOM_BYTES  = 460;
	localparam int RANDOM_LINES  = 15;
	localparam int IDLE_LIMIT    = 5000;
	localparam int REPORT_LIMIT  = 10;

	typedef enum logic [3:0] {
		M_UNKNOWN, M_GET, M_HEAD, M_POST, M_PUT,
		M_DELETE, M_TRACE, M_OPTIONS, M_CONNECT, M_PATCH
	} method_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 byte_valid = 1'b0;
	logic                 byte_stall;
	hrlp_pkg::hrlp_byte_t byte_data = '0;
	logic                 line_valid;
	logic                 line_stall = 1'b0;
	hrlp_pkg::hrlp_line_t line_data;

	http_request_line_parser_core #(
		.LINE_MAX_BYTES(LINE_MAX)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data (byte_data),
		.line_valid(line_valid),
		.line_stall(line_stall),
		.line_data (line_data)
	);

	always #6 clk = ~clk;

	string method_names [METHOD_TOTAL] = '{
		"UNKNOWN", "GET", "HEAD", "POST", "PUT",
		"DELETE", "TRACE", "OPTIONS", "CONNECT", "PATCH"
	};
	string versions [6] = '{"HTTP/1.1", "HTTP/1.0", "HTTP/1.1", "HTTP/2.0", "HTTP/1.",
		"HHTTP/1.0"};
	string ver_lead    = "HTTP/";
	string path_chars  = "abz09/..-_?~% ";
	string query_chars = "k=v&?.";

	// line scanner state
	int         line_pos;
	int         space_pos;
	int         res_qm_pos;
	int         res_sp_pos;
	int         qm_pos;
	int         query_sp_pos;
	int         dotdot_pos;
	logic [9:0] method_live;
	logic [3:0] ver_state;
	logic [1:0] ver_seen;
	logic [7:0] prev_char;
	logic       cr_held;
	logic       slash_lead;
	logic       too_long;

	hrlp_pkg::hrlp_line_t expected_lines [$];
	logic [7:0] req_bytes [$];
	logic       req_ends_stream;
	int         bytes_sent = 0;
	int         lines_predicted = 0;
	int         error_count = 0;
	int         burst_left = 1;
	int         idle_cycles = 0;
	int         stall_mode = 0;
	int         stall_run = 0;

	function void clear_line_state();
		line_pos     = 0;
		space_pos    = NO_POS;
		res_qm_pos   = NO_POS;
		res_sp_pos   = NO_POS;
		qm_pos       = NO_POS;
		query_sp_pos = NO_POS;
		dotdot_pos   = NO_POS;
		method_live  = '1;
		ver_state    = hrlp_pkg::VS_SEARCH;
		ver_seen     = hrlp_pkg::VER_UNKNOWN;
		prev_char    = 8'h00;
		cr_held      = 1'b0;
		slash_lead   = 1'b0;
		too_long     = 1'b0;
	endfunction

	function void scan_char(logic [7:0] b);
		int p;
		p = line_pos;
		if (p >= LINE_MAX) begin
			too_long = 1'b1;
			return;
		end
		for (int i = 0; i < METHOD_TOTAL; i++)
			if (p < method_names[i].len() && method_names[i][p] != b)
				method_live[i] = 1'b0;
		if (b == hrlp_pkg::CH_SP) begin
			if (space_pos == NO_POS)
				space_pos = p;
			else if (res_sp_pos == NO_POS)
				res_sp_pos = p;
			if (qm_pos != NO_POS && query_sp_pos == NO_POS)
				query_sp_pos = p;
		end else if (b == hrlp_pkg::CH_QM) begin
			if (qm_pos == NO_POS)
				qm_pos = p;
			if (space_pos != NO_POS && res_qm_pos == NO_POS)
				res_qm_pos = p;
		end
		if (space_pos != NO_POS) begin
			if (b == hrlp_pkg::CH_SLASH && p == space_pos + 1)
				slash_lead = 1'b1;
			if (b == hrlp_pkg::CH_DOT && prev_char == hrlp_pkg::CH_DOT &&
			    p >= space_pos + 2 && dotdot_pos == NO_POS)
				dotdot_pos = p - 1;
		end
		if (ver_state < hrlp_pkg::VS_MAJOR) begin
			if (b == ver_lead[ver_state])
				ver_state = ver_state + 4'd1;
			else
				ver_state = (b == hrlp_pkg::CH_H) ? hrlp_pkg::VS_SEARCH + 4'd1
				                                  : hrlp_pkg::VS_SEARCH;
		end else begin
			case (ver_state)
				hrlp_pkg::VS_MAJOR:
					ver_state = (b == hrlp_pkg::CH_ONE) ? hrlp_pkg::VS_DOT : hrlp_pkg::VS_DONE;
				hrlp_pkg::VS_DOT:
					ver_state = (b == hrlp_pkg::CH_DOT) ? hrlp_pkg::VS_MINOR : hrlp_pkg::VS_DONE;
				hrlp_pkg::VS_MINOR: begin
					if (b == hrlp_pkg::CH_ZERO)
						ver_seen = hrlp_pkg::VER_1_0;
					else if (b == hrlp_pkg::CH_ONE)
						ver_seen = hrlp_pkg::VER_1_1;
					ver_state = hrlp_pkg::VS_DONE;
				end
				default: ;
			endcase
		end
		prev_char = b;
		line_pos = p + 1;
	endfunction

	function hrlp_pkg::hrlp_line_t close_line();
		hrlp_pkg::hrlp_line_t r;
		method_e    m;
		int         len;
		int         end_p;
		int         rs;
		int         rl;
		int         qs;
		int         ql;
		logic       rfound;
		logic       qfound;
		logic       parent;
		len = line_pos;
		m = M_UNKNOWN;
		rfound = 1'b0;
		qfound = 1'b0;
		parent = 1'b0;
		rs = 0;
		rl = 0;
		qs = 0;
		ql = 0;
		for (int i = 0; i < METHOD_TOTAL; i++)
			if (method_live[i] && len >= method_names[i].len()) begin
				m = method_e'(i);
				break;
			end
		if (space_pos != NO_POS) begin
			end_p = (res_qm_pos != NO_POS) ? res_qm_pos : res_sp_pos;
			if (end_p != NO_POS) begin
				rfound = 1'b1;
				rs = space_pos + 1;
				rl = end_p - rs;
				if (dotdot_pos != NO_POS && dotdot_pos + 1 < end_p)
					parent = 1'b1;
				if (rl > 0 && slash_lead) begin
					rs++;
					rl--;
				end
			end
		end
		if (qm_pos != NO_POS && query_sp_pos != NO_POS) begin
			qfound = 1'b1;
			qs = qm_pos + 1;
			ql = query_sp_pos - qs;
		end
		r.method_code     = m;
		r.version_code    = ver_seen;
		r.resource_found  = rfound;
		r.resource_start  = rs[11:0];
		r.resource_length = rl[11:0];
		r.query_found     = qfound;
		r.query_start     = qs[11:0];
		r.query_length    = ql[11:0];
		r.parent_ref      = parent;
		if (too_long || m == M_UNKNOWN || !rfound || ver_seen == hrlp_pkg::VER_UNKNOWN)
			r.verdict = hrlp_pkg::VERDICT_BAD;
		else if (parent)
			r.verdict = hrlp_pkg::VERDICT_FORBID;
		else
			r.verdict = hrlp_pkg::VERDICT_ACCEPT;
		r.line_length   = len[12:0];
		r.line_overflow = too_long;
		clear_line_state();
		lines_predicted++;
		return r;
	endfunction

	function void predict_byte(logic [7:0] b, logic is_last);
		if (cr_held) begin
			cr_held = 1'b0;
			if (b == hrlp_pkg::CH_LF) begin
				expected_lines.push_back(close_line());
				return;
			end
			scan_char(hrlp_pkg::CH_CR);
		end
		if (is_last) begin
			scan_char(b);
			expected_lines.push_back(close_line());
			return;
		end
		if (b == hrlp_pkg::CH_CR) begin
			cr_held = 1'b1;
			return;
		end
		scan_char(b);
	endfunction

	function string line_text(hrlp_pkg::hrlp_line_t l);
		return $sformatf("m=%0d v=%0d res=%0d/%0d/%0d qry=%0d/%0d/%0d par=%0d vd=%0d len=%0d ovf=%0d",
			l.method_code, l.version_code, l.resource_found, l.resource_start,
			l.resource_length, l.query_found, l.query_start, l.query_length,
			l.parent_ref, l.verdict, l.line_length, l.line_overflow);
	endfunction

	function string diff_fields(hrlp_pkg::hrlp_line_t w, hrlp_pkg::hrlp_line_t g);
		string s;
		s = "";
		if (w.method_code !== g.method_code)         s = {s, " method_code"};
		if (w.version_code !== g.version_code)       s = {s, " version_code"};
		if (w.resource_found !== g.resource_found)   s = {s, " resource_found"};
		if (w.resource_start !== g.resource_start)   s = {s, " resource_start"};
		if (w.resource_length !== g.resource_length) s = {s, " resource_length"};
		if (w.query_found !== g.query_found)         s = {s, " query_found"};
		if (w.query_start !== g.query_start)         s = {s, " query_start"};
		if (w.query_length !== g.query_length)       s = {s, " query_length"};
		if (w.parent_ref !== g.parent_ref)           s = {s, " parent_ref"};
		if (w.verdict !== g.verdict)                 s = {s, " verdict"};
		if (w.line_length !== g.line_length)         s = {s, " line_length"};
		if (w.line_overflow !== g.line_overflow)     s = {s, " line_overflow"};
		return s;
	endfunction

	// line channel checker
	always @(posedge clk) begin
		hrlp_pkg::hrlp_line_t want;
		string      diffs;
		if (arst_n && line_valid && !line_stall) begin
			if (expected_lines.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("%0t: unexpected line transaction: %s", $time, line_text(line_data));
			end else begin
				want = expected_lines.pop_front();
				diffs = diff_fields(want, line_data);
				if (diffs != "") begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("%0t: line mismatch in%s\n  exp %s\n  got %s", $time, diffs,
							line_text(want), line_text(line_data));
				end
			end
		end
	end

	// receiver stall pattern: runs of no stall, random stall, and heavy stall
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_run = $urandom_range(20, 200);
		end else
			stall_run--;
		case (stall_mode)
			0:       line_stall <= 1'b0;
			1:       line_stall <= 1'($urandom_range(0, 1));
			default: line_stall <= ($urandom_range(0, 15) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (line_valid && !line_stall))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("[http_request_line_parser_core] ERROR");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task send_byte(input logic [7:0] b, input logic is_last);
		byte_data <= '{data_byte: b, stream_end: is_last};
		byte_valid <= 1'b1;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		predict_byte(b, is_last);
		bytes_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			byte_valid <= 1'b0;
			repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4))
				@(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
		end
	endtask

	task send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	task send_line(input string s);
		send_text(s);
		send_byte(hrlp_pkg::CH_CR, 1'b0);
		send_byte(hrlp_pkg::CH_LF, 1'b0);
	endtask

	task send_last(input string s);
		send_text(s.substr(0, s.len() - 2));
		send_byte(s[s.len() - 1], 1'b1);
	endtask

	task push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			req_bytes.push_back(s[i]);
	endtask

	task send_request();
		for (int i = 0; i < req_bytes.size(); i++)
			send_byte(req_bytes[i], req_ends_stream && i == req_bytes.size() - 1);
	endtask

	task wait_for_lines();
		byte_valid <= 1'b0;
		wait (expected_lines.size() == 0);
		@(posedge clk);
	endtask

	task compose_request();
		int n;
		req_bytes.delete();
		req_ends_stream = 1'b0;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, 24);
			repeat (n) req_bytes.push_back(8'($urandom_range(0, 255)));
			req_ends_stream = 1'b1;
			return;
		end
		case ($urandom_range(0, 9))
			0:       push_text(method_names[$urandom_range(0, 9)].substr(0, $urandom_range(0, 3)));
			1:       push_text("UNKNOWN");
			default: push_text(method_names[$urandom_range(1, 9)]);
		endcase
		if ($urandom_range(0, 15) != 0)
			req_bytes.push_back(hrlp_pkg::CH_SP);
		if ($urandom_range(0, 3) != 0)
			req_bytes.push_back(hrlp_pkg::CH_SLASH);
		n = $urandom_range(0, 12);
		repeat (n) req_bytes.push_back(path_chars[$urandom_range(0, path_chars.len() - 1)]);
		if ($urandom_range(0, 2) == 0) begin
			req_bytes.push_back(hrlp_pkg::CH_QM);
			n = $urandom_range(0, 8);
			repeat (n) req_bytes.push_back(query_chars[$urandom_range(0, query_chars.len() - 1)]);
		end
		if ($urandom_range(0, 9) != 0)
			req_bytes.push_back(hrlp_pkg::CH_SP);
		push_text(versions[$urandom_range(0, 5)]);
		case ($urandom_range(0, 9))
			0: req_ends_stream = 1'b1;
			1: begin
				push_text("\x0d\x0a");
				req_ends_stream = 1'b1;
			end
			2: begin
				req_bytes.push_back(hrlp_pkg::CH_CR);
				req_ends_stream = 1'b1;
			end
			3: push_text("\x0dx\x0d\x0a");
			4: push_text("\x0d\x0d\x0a");
			default: push_text("\x0d\x0a");
		endcase
	endtask

	task test_methods();
		for (int i = 0; i < METHOD_TOTAL; i++)
			send_line({method_names[i], " /x HTTP/1.1"});
		send_last("GE");
		send_line("PATC /x HTTP/1.1");
	endtask

	task test_spans();
		send_line("HEAD /a?q=1 HTTP/1.0");
		send_line("GET /../etc HTTP/1.1");
		send_line("GET ?a?b c HTTP/1.1");
		send_line("GET / HTTP/1.1");
		send_line("GET // HTTP/1.1");
		send_line("GET a.. HTTP/1.1");
		send_line("GET");
		send_last("GET /abc");
		send_line("HTTP/1.1 x");
		send_line("GET /x HTTP/2.0");
		send_last("GET /x HTTP/1.");
	endtask

	task test_line_endings();
		send_text("GET /a");
		send_byte(hrlp_pkg::CH_CR, 1'b0);
		send_line(" HTTP/1.1");
		send_text("GET /");
		send_byte(hrlp_pkg::CH_LF, 1'b0);
		send_line(" HTTP/1.1");
		send_text("GET / HTTP/1.1");
		send_byte(hrlp_pkg::CH_CR, 1'b0);
		send_byte(hrlp_pkg::CH_LF, 1'b1);
		send_text("GET /");
		send_byte(8'h00, 1'b0);
		send_line(" HTTP/1.1");
		send_line("");
		send_text("PUT /b HTTP/1.0");
		send_byte(hrlp_pkg::CH_CR, 1'b1);
		send_text("GET /c HTTP/1.1");
		send_byte(hrlp_pkg::CH_CR, 1'b0);
		send_line("");
		send_byte(8'hFF, 1'b1);
	endtask

	task test_random_requests();
		int byte_goal;
		int line_goal;
		int count;
		byte_goal = bytes_sent + RANDOM_BYTES;
		line_goal = lines_predicted + RANDOM_LINES;
		count = 0;
		while (bytes_sent < byte_goal || lines_predicted < line_goal) begin
			compose_request();
			send_request();
			count++;
			if (count % 20 == 0)
				wait_for_lines();
		end
	endtask

	initial begin
		clear_line_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_methods();
		test_spans();
		test_line_endings();
		wait_for_lines();
		test_random_requests();
		wait_for_lines();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("[http_request_line_parser_core] OK");
		else
			$display("[http_request_line_parser_core] ERROR");
		$finish;
	end

endmodule
